/* hw/rtl/gregorian_date_step_assert.svh */
// ----------------------------------------------------------------------------
// Gregorian date step assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_STEP_ASSERT_SVH
`define GREGORIAN_DATE_STEP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GDS_ASSERT_COMB(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gregorian_date_step: assertion failed");
// Next-cycle implication.
`define GDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gregorian_date_step: assertion failed");
`else
`define GDS_ASSERT_COMB(label, clk, rst_n, ante, cons)
`define GDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/gds_pkg.sv */
// ----------------------------------------------------------------------------
// gds_pkg
// Widths, reciprocal constants and month tables for the date step block.
// ----------------------------------------------------------------------------
`default_nettype none

package gds_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 15;
    localparam int ORD_W  = 9;
    localparam int WEEK_W = 6;

    // Quotient of |year| / 25, exact for |year| up to 2^14.
    localparam int Q25_W       = 10;
    localparam int RECIP25     = 5243;
    localparam int RECIP25_SH  = 17;
    localparam int PROD25_W    = 28;
    localparam int CENT_FACTOR = 25;

    // Quotient of ordinal day / 7, exact for values up to 366.
    localparam int RECIP7    = 293;
    localparam int RECIP7_SH = 11;
    localparam int PROD7_W   = 18;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;
    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0] DAY_DEC_LAST = 5'd31;

    function automatic logic [DAY_W-1:0] month_len(
        input logic [MON_W-1:0] mon,
        input logic             leap
    );
        logic [DAY_W-1:0] len;
        case (mon)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the months before mon.
    function automatic logic [ORD_W-1:0] days_before(
        input logic [MON_W-1:0] mon,
        input logic             leap
    );
        logic [ORD_W-1:0] base;
        case (mon)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && mon > MON_FEB) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/gds_in_if.sv */
// ----------------------------------------------------------------------------
// gds_in_if
// Date input channel: valid/ready handshake with one date as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gds_in_if;
    import gds_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [DAY_W-1:0]         day_in;
    logic [MON_W-1:0]         month_in;
    logic signed [YEAR_W-1:0] year_in;

    modport source (output valid, output day_in, output month_in, output year_in,
                    input ready);
    modport sink   (input valid, input day_in, input month_in, input year_in,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/gds_out_if.sv */
// ----------------------------------------------------------------------------
// gds_out_if
// Result channel: valid/ready handshake carrying the date step result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gds_out_if;
    import gds_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [DAY_W-1:0]         next_day_of_month;
    logic [MON_W-1:0]         next_month_num;
    logic signed [YEAR_W-1:0] next_year_num;
    logic [DAY_W-1:0]         prev_day_of_month;
    logic [MON_W-1:0]         prev_month_num;
    logic signed [YEAR_W-1:0] prev_year_num;
    logic                     leap_flag;
    logic [ORD_W-1:0]         ordinal_day;
    logic [WEEK_W-1:0]        week_of_year;
    logic                     date_valid;

    modport source (output valid, output next_day_of_month, output next_month_num,
                    output next_year_num, output prev_day_of_month,
                    output prev_month_num, output prev_year_num, output leap_flag,
                    output ordinal_day, output week_of_year, output date_valid,
                    input ready);
    modport sink   (input valid, input next_day_of_month, input next_month_num,
                    input next_year_num, input prev_day_of_month,
                    input prev_month_num, input prev_year_num, input leap_flag,
                    input ordinal_day, input week_of_year, input date_valid,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/gregorian_date_step.sv */
// ----------------------------------------------------------------------------
// gregorian_date_step
// Next day, previous day, leap flag, day of year and week of one date.
// ----------------------------------------------------------------------------
// The block takes one Gregorian date per clock unless its output stalls.
// It is a four-stage pipeline: the absolute year and its reciprocal product
// for division by 25; the leap decision and month table lookups; rollover
// and the day of year; the division by seven and the output register. Each
// stage holds its own valid bit and takes new data whenever it is empty or
// its successor moves, so bubbles close up and a stalled output still lets
// the earlier stages fill. Invalid dates produce a result with every field
// zero.
`default_nettype none

`include "gregorian_date_step_assert.svh"

module gregorian_date_step (
    input wire logic i_clk,
    input wire logic i_rst_n,
    gds_in_if.sink   i_in,
    gds_out_if.source o_out
);
    import gds_pkg::*;

    // Handshake chain.
    logic w_en1, w_en2, w_en3, w_en4;
    logic r1_v, r2_v, r3_v, r4_v;

    assign w_en4 = !r4_v || o_out.ready;
    assign w_en3 = !r3_v || w_en4;
    assign w_en2 = !r2_v || w_en3;
    assign w_en1 = !r1_v || w_en2;
    assign i_in.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_in.valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
            if (w_en4) r4_v <= r3_v;
        end
    end

    // Stage 1: absolute year and reciprocal product.
    logic [YEAR_W-1:0]        n1_abs;
    logic [PROD25_W-1:0]      w_prod25;
    logic [DAY_W-1:0]         r1_day;
    logic [MON_W-1:0]         r1_mon;
    logic signed [YEAR_W-1:0] r1_year;
    logic [YEAR_W-1:0]        r1_abs;
    logic [Q25_W-1:0]         r1_q25;

    assign n1_abs   = i_in.year_in[YEAR_W-1] ? (~i_in.year_in + 1'b1) : i_in.year_in;
    assign w_prod25 = PROD25_W'(n1_abs) * PROD25_W'(RECIP25);

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_day  <= i_in.day_in;
            r1_mon  <= i_in.month_in;
            r1_year <= i_in.year_in;
            r1_abs  <= n1_abs;
            r1_q25  <= w_prod25[RECIP25_SH +: Q25_W];
        end
    end

    // Stage 2: leap decision, validity and month table lookups.
    logic             w_leap;
    logic [DAY_W-1:0] n2_len;
    logic             n2_valid;
    logic [DAY_W-1:0]         r2_day;
    logic [MON_W-1:0]         r2_mon;
    logic signed [YEAR_W-1:0] r2_year;
    logic [DAY_W-1:0]         r2_len;
    logic [DAY_W-1:0]         r2_prev_len;
    logic [ORD_W-1:0]         r2_cum;
    logic                     r2_leap;
    logic                     r2_valid;

    gds_leap u_leap (
        .i_abs_year (r1_abs),
        .i_q25      (r1_q25),
        .o_leap     (w_leap)
    );

    always_comb begin
        n2_len   = month_len(r1_mon, w_leap);
        n2_valid = (r1_mon inside {[MON_JAN:MON_DEC]}) && (r1_day >= DAY_FIRST)
                   && (r1_day <= n2_len);
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_day      <= r1_day;
            r2_mon      <= r1_mon;
            r2_year     <= r1_year;
            r2_len      <= n2_len;
            r2_prev_len <= month_len(r1_mon - 1'b1, w_leap);
            r2_cum      <= days_before(r1_mon, w_leap);
            r2_leap     <= w_leap;
            r2_valid    <= n2_valid;
        end
    end

    // Stage 3: rollover in both directions and day of year.
    logic [DAY_W-1:0]         n3_nd, n3_pd;
    logic [MON_W-1:0]         n3_nm, n3_pm;
    logic signed [YEAR_W-1:0] n3_ny, n3_py;
    logic [DAY_W-1:0]         r3_nd, r3_pd;
    logic [MON_W-1:0]         r3_nm, r3_pm;
    logic signed [YEAR_W-1:0] r3_ny, r3_py;
    logic [ORD_W-1:0]         r3_ord;
    logic                     r3_leap;
    logic                     r3_valid;

    always_comb begin
        n3_nd = r2_day + 1'b1;
        n3_nm = r2_mon;
        n3_ny = r2_year;
        if (r2_day == r2_len) begin
            n3_nd = DAY_FIRST;
            if (r2_mon == MON_DEC) begin
                n3_nm = MON_JAN;
                n3_ny = r2_year + 1'b1;
            end else begin
                n3_nm = r2_mon + 1'b1;
            end
        end
        n3_pd = r2_day - 1'b1;
        n3_pm = r2_mon;
        n3_py = r2_year;
        if (r2_day == DAY_FIRST) begin
            if (r2_mon == MON_JAN) begin
                n3_pd = DAY_DEC_LAST;
                n3_pm = MON_DEC;
                n3_py = r2_year - 1'b1;
            end else begin
                n3_pd = r2_prev_len;
                n3_pm = r2_mon - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_nd    <= n3_nd;
            r3_nm    <= n3_nm;
            r3_ny    <= n3_ny;
            r3_pd    <= n3_pd;
            r3_pm    <= n3_pm;
            r3_py    <= n3_py;
            r3_ord   <= r2_cum + ORD_W'(r2_day);
            r3_leap  <= r2_leap;
            r3_valid <= r2_valid;
        end
    end

    // Stage 4: week number and zeroing of invalid dates into the output register.
    logic [PROD7_W-1:0]       w_prod7;
    logic [WEEK_W-1:0]        n4_week;
    logic [DAY_W-1:0]         r4_nd, r4_pd;
    logic [MON_W-1:0]         r4_nm, r4_pm;
    logic signed [YEAR_W-1:0] r4_ny, r4_py;
    logic [ORD_W-1:0]         r4_ord;
    logic [WEEK_W-1:0]        r4_week;
    logic                     r4_leap;
    logic                     r4_valid;

    assign w_prod7 = PROD7_W'(r3_ord) * PROD7_W'(RECIP7);
    assign n4_week = w_prod7[RECIP7_SH +: WEEK_W] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_nd    <= r3_valid ? r3_nd : '0;
            r4_nm    <= r3_valid ? r3_nm : '0;
            r4_ny    <= r3_valid ? r3_ny : '0;
            r4_pd    <= r3_valid ? r3_pd : '0;
            r4_pm    <= r3_valid ? r3_pm : '0;
            r4_py    <= r3_valid ? r3_py : '0;
            r4_ord   <= r3_valid ? r3_ord : '0;
            r4_week  <= r3_valid ? n4_week : '0;
            r4_leap  <= r3_valid && r3_leap;
            r4_valid <= r3_valid;
        end
    end

    assign o_out.valid             = r4_v;
    assign o_out.next_day_of_month = r4_nd;
    assign o_out.next_month_num    = r4_nm;
    assign o_out.next_year_num     = r4_ny;
    assign o_out.prev_day_of_month = r4_pd;
    assign o_out.prev_month_num    = r4_pm;
    assign o_out.prev_year_num     = r4_py;
    assign o_out.leap_flag         = r4_leap;
    assign o_out.ordinal_day       = r4_ord;
    assign o_out.week_of_year      = r4_week;
    assign o_out.date_valid        = r4_valid;

    // An empty output register must leave the whole pipeline open.
    `GDS_ASSERT_COMB(a_ready_when_empty, i_clk, i_rst_n, !o_out.valid, i_in.ready)
    // An accepted transaction always lands in the first stage.
    `GDS_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in.valid && i_in.ready, r1_v)
    // An invalid date carries zero days, day of year, week and leap flag.
    `GDS_ASSERT_COMB(a_invalid_zero, i_clk, i_rst_n, o_out.valid && !o_out.date_valid, (o_out.next_day_of_month == '0) && (o_out.prev_day_of_month == '0) && (o_out.ordinal_day == '0) && (o_out.week_of_year == '0) && !o_out.leap_flag)
    // A valid date has a nonzero day of year and week.
    `GDS_ASSERT_COMB(a_valid_nonzero, i_clk, i_rst_n, o_out.valid && o_out.date_valid, (o_out.ordinal_day != '0) && (o_out.week_of_year != '0))

endmodule

`default_nettype wire

/* hw/rtl/gds_leap.sv */
// ----------------------------------------------------------------------------
// gds_leap
// Leap-year decision from |year| and the precomputed quotient |year| / 25.
// ----------------------------------------------------------------------------
`default_nettype none

module gds_leap (
    input  wire logic [gds_pkg::YEAR_W-1:0] i_abs_year,
    input  wire logic [gds_pkg::Q25_W-1:0]  i_q25,
    output      logic                       o_leap
);
    import gds_pkg::*;

    logic [YEAR_W-1:0] w_rem25;
    logic              w_div25;
    logic              w_div4;
    logic              w_div16;

    // Divisible by 100 means by 4 and 25; by 400 means by 16 and 25.
    assign w_rem25 = i_abs_year - YEAR_W'(YEAR_W'(i_q25) * YEAR_W'(CENT_FACTOR));
    assign w_div25 = (w_rem25 == '0);
    assign w_div4  = (i_abs_year[1:0] == 2'b00);
    assign w_div16 = (i_abs_year[3:0] == 4'b0000);
    assign o_leap  = (w_div4 && !w_div25) || (w_div16 && w_div25);

endmodule

`default_nettype wire
